@@ hdl/block_matrix_ops_5x5_macros.svh @@
// Assertion macros for the matrix operation block.
// Each expects clk and rst_n in scope at the point of use.
`ifndef BLOCK_MATRIX_OPS_5X5_MACROS_SVH
`define BLOCK_MATRIX_OPS_5X5_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BMO_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmo assertion failed: same-cycle implication");

`define BMO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmo assertion failed: next-cycle implication");

`else

`define BMO_ASSERT_IMPLIES(lbl, ante, cons)

`define BMO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/bmo_pkg.sv @@
`default_nettype none

package bmo_pkg;

    localparam int DIM_DEF       = 5;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W = 32;
    localparam int ROW_W  = 3;
    localparam int OP_W   = 3;
    localparam int PC_W   = 4;

    // op_mode codes
    localparam logic [OP_W-1:0] OP_MAT_MUL = 3'd0;
    localparam logic [OP_W-1:0] OP_MAT_ADD = 3'd1;
    localparam logic [OP_W-1:0] OP_MAT_SUB = 3'd2;
    localparam logic [OP_W-1:0] OP_MAT_VEC = 3'd3;
    localparam logic [OP_W-1:0] OP_VEC_ADD = 3'd4;
    localparam logic [OP_W-1:0] OP_VEC_SUB = 3'd5;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD_PROD,
        ACC_LOAD_SUM
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_L_MORE,
        JMP_CELL_MORE
    } jmp_t;

    // One microcode word
    typedef struct packed {
        acc_op_t          acc_op;
        logic             clr_rc;
        logic             clr_l;
        logic             adv_l;
        logic             rd;
        logic             mul;
        logic             emit;
        logic             term_addr;
        logic             shift;
        logic             halt;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } uop_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic    rd;
        logic    mul;
        logic    term_addr;
        logic    shift;
        acc_op_t acc_op;
    } ctl_t;

    // Program addresses
    localparam logic [PC_W-1:0] PC_MM_START = 4'd0;
    localparam logic [PC_W-1:0] PC_MM_TERM  = 4'd1;
    localparam logic [PC_W-1:0] PC_MM_RD    = 4'd2;
    localparam logic [PC_W-1:0] PC_MM_MUL   = 4'd3;
    localparam logic [PC_W-1:0] PC_MM_ACC   = 4'd4;
    localparam logic [PC_W-1:0] PC_MM_EMIT  = 4'd5;
    localparam logic [PC_W-1:0] PC_MM_HALT  = 4'd6;
    localparam logic [PC_W-1:0] PC_EW_START = 4'd7;
    localparam logic [PC_W-1:0] PC_EW_RD    = 4'd8;
    localparam logic [PC_W-1:0] PC_EW_SUM   = 4'd9;
    localparam logic [PC_W-1:0] PC_EW_EMIT  = 4'd10;
    localparam logic [PC_W-1:0] PC_EW_HALT  = 4'd11;

    // Control store. Product program: per result, clear, then read/mul/acc
    // per term, then emit. Elementwise program: read, add/sub, emit.
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        u        = '0;
        u.acc_op = ACC_HOLD;
        u.jmp    = JMP_NEXT;
        unique case (pc)
            PC_MM_START: u.clr_rc = 1'b1;
            PC_MM_TERM:
            begin
                u.clr_l  = 1'b1;
                u.acc_op = ACC_CLR;
            end
            PC_MM_RD:
            begin
                u.rd        = 1'b1;
                u.term_addr = 1'b1;
            end
            PC_MM_MUL: u.mul = 1'b1;
            PC_MM_ACC:
            begin
                u.acc_op = ACC_ADD_PROD;
                u.adv_l  = 1'b1;
                u.jmp    = JMP_L_MORE;
                u.target = PC_MM_RD;
            end
            PC_MM_EMIT:
            begin
                u.emit   = 1'b1;
                u.shift  = 1'b1;
                u.jmp    = JMP_CELL_MORE;
                u.target = PC_MM_TERM;
            end
            PC_MM_HALT: u.halt = 1'b1;
            PC_EW_START: u.clr_rc = 1'b1;
            PC_EW_RD: u.rd = 1'b1;
            PC_EW_SUM: u.acc_op = ACC_LOAD_SUM;
            PC_EW_EMIT:
            begin
                u.emit   = 1'b1;
                u.jmp    = JMP_CELL_MORE;
                u.target = PC_EW_RD;
            end
            PC_EW_HALT: u.halt = 1'b1;
            default: u.halt = 1'b1;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ hdl/block_matrix_ops_5x5.sv @@
// Channel  Handshake            Payload
// in       in_valid/in_ready    operand_sel, elem_row, elem_col, elem_value, end_of_cell
// out      out_valid/out_ready  out_row, out_col, out_value, saturated, last_out
// cfg      cfg_we               cfg_wdata (op_mode)
//
// Loading: one element per cycle while idle. An end_of_cell transfer starts the
// microcode program when op_mode is a defined code; in_ready stays low until it halts.
// Matrix product and mat-vec use one shared multiplier, three control steps per
// term; elementwise: read, add/sub, emit per result.
// Output stalls hold the sequencer on its emit step. Reset clears control only;
// operand memories are not cleared.
`default_nettype none
`include "block_matrix_ops_5x5_macros.svh"

module block_matrix_ops_5x5 #(
    parameter int DIM       = bmo_pkg::DIM_DEF,
    parameter int FRAC_BITS = bmo_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bmo_pkg::OP_W-1:0]     cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operand_sel,
    input  logic [bmo_pkg::ROW_W-1:0]    elem_row,
    input  logic [bmo_pkg::ROW_W-1:0]    elem_col,
    input  logic [bmo_pkg::DATA_W-1:0]   elem_value,
    input  logic                         end_of_cell,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bmo_pkg::ROW_W-1:0]    out_row,
    output logic [bmo_pkg::ROW_W-1:0]    out_col,
    output logic [bmo_pkg::DATA_W-1:0]   out_value,
    output logic                         saturated,
    output logic                         last_out
);
    import bmo_pkg::*;

    localparam int CNT_W = $clog2(DIM);
    localparam logic [ROW_W:0] DIM_LIM = (ROW_W+1)'(DIM);

    logic [OP_W-1:0]    op_mode_reg;
    logic               in_xfer;
    logic               wr_en;
    logic               op_ok;
    logic               start;
    logic               sub;
    logic               out_full;

    ctl_t               ctl;
    logic               emit;
    logic               last;
    logic               busy;
    logic [CNT_W-1:0]   r, c, l;
    logic [DATA_W-1:0]  res_value;
    logic               res_sat;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg, out_col_reg;
    logic [DATA_W-1:0]  out_value_reg;
    logic               saturated_reg;
    logic               last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_mode_reg <= OP_MAT_MUL;
        else if (cfg_we)
            op_mode_reg <= cfg_wdata;
    end

    assign in_ready = !busy;
    assign in_xfer  = in_valid && in_ready;
    // out-of-range positions are dropped, end_of_cell still acts
    assign wr_en    = in_xfer && ({1'b0, elem_row} < DIM_LIM) &&
                      ({1'b0, elem_col} < DIM_LIM);
    assign op_ok    = (op_mode_reg == OP_MAT_MUL) || (op_mode_reg == OP_MAT_ADD) ||
                      (op_mode_reg == OP_MAT_SUB) || (op_mode_reg == OP_MAT_VEC) ||
                      (op_mode_reg == OP_VEC_ADD) || (op_mode_reg == OP_VEC_SUB);
    assign start    = in_xfer && end_of_cell && op_ok;
    assign sub      = (op_mode_reg == OP_MAT_SUB) || (op_mode_reg == OP_VEC_SUB);
    assign out_full = out_valid_reg && !out_ready;

    bmo_seq #(
        .DIM (DIM)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op_mode  (op_mode_reg),
        .out_full (out_full),
        .ctl      (ctl),
        .emit     (emit),
        .last     (last),
        .busy     (busy),
        .r        (r),
        .c        (c),
        .l        (l)
    );

    bmo_dpath #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_sel    (operand_sel),
        .wr_row    (elem_row),
        .wr_col    (elem_col),
        .wr_data   (elem_value),
        .ctl       (ctl),
        .r         (r),
        .c         (c),
        .l         (l),
        .sub       (sub),
        .res_value (res_value),
        .res_sat   (res_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg   <= ROW_W'(r);
            out_col_reg   <= ROW_W'(c);
            out_value_reg <= res_value;
            saturated_reg <= res_sat;
            last_out_reg  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign saturated = saturated_reg;
    assign last_out  = last_out_reg;

    `BMO_ASSERT_IMPLIES(a_emit_no_overwrite, emit, !out_valid || out_ready)
    `BMO_ASSERT_NEXT(a_emit_shows, emit, out_valid)
    `BMO_ASSERT_NEXT(a_start_blocks_input, start, !in_ready)
    `BMO_ASSERT_IMPLIES(a_no_emit_idle, !busy, !emit)

endmodule

`default_nettype wire

@@ hdl/bmo_seq.sv @@
`default_nettype none

module bmo_seq #(
    parameter int DIM = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bmo_pkg::OP_W-1:0]    op_mode,
    input  logic                        out_full,
    output bmo_pkg::ctl_t               ctl,
    output logic                        emit,
    output logic                        last,
    output logic                        busy,
    output logic [$clog2(DIM)-1:0]      r,
    output logic [$clog2(DIM)-1:0]      c,
    output logic [$clog2(DIM)-1:0]      l
);
    import bmo_pkg::*;

    localparam int CNT_W = $clog2(DIM);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIM - 1);

    logic              busy_reg, busy_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  c_reg, c_next;
    logic [CNT_W-1:0]  l_reg, l_next;

    uop_t              uop;
    logic              hold;
    logic              step;
    logic              vec;
    logic              l_last, c_last, r_last;
    logic              cell_more;
    logic              taken;
    logic [PC_W-1:0]   entry;

    assign vec = (op_mode == OP_MAT_VEC) || (op_mode == OP_VEC_ADD) ||
                 (op_mode == OP_VEC_SUB);
    assign entry = ((op_mode == OP_MAT_MUL) || (op_mode == OP_MAT_VEC)) ?
                   PC_MM_START : PC_EW_START;

    assign uop    = ucode(pc_reg);
    assign hold   = busy_reg && uop.emit && out_full;
    assign step   = busy_reg && !hold;
    assign l_last = (l_reg == CNT_LAST);
    assign c_last = (c_reg == CNT_LAST);
    assign r_last = (r_reg == CNT_LAST);
    // vector results walk rows only, column stays 0
    assign cell_more = vec ? !r_last : !(r_last && c_last);

    always_comb
    begin
        unique case (uop.jmp)
            JMP_NEXT:      taken = 1'b0;
            JMP_L_MORE:    taken = !l_last;
            JMP_CELL_MORE: taken = cell_more;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        r_next    = r_reg;
        c_next    = c_reg;
        l_next    = l_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = entry;
            end
        end
        else if (step)
        begin
            if (uop.halt)
                busy_next = 1'b0;
            else if (taken)
                pc_next = uop.target;
            else
                pc_next = pc_reg + PC_W'(1);

            if (uop.clr_rc)
            begin
                r_next = '0;
                c_next = '0;
            end
            if (uop.clr_l)
                l_next = '0;
            if (uop.adv_l)
                l_next = l_reg + CNT_W'(1);
            if (uop.emit)
            begin
                if (vec || c_last)
                begin
                    c_next = '0;
                    r_next = r_reg + CNT_W'(1);
                end
                else
                    c_next = c_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_MM_START;
            r_reg    <= '0;
            c_reg    <= '0;
            l_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            r_reg    <= r_next;
            c_reg    <= c_next;
            l_reg    <= l_next;
        end
    end

    always_comb
    begin
        ctl.rd        = step && uop.rd;
        ctl.mul       = step && uop.mul;
        ctl.term_addr = uop.term_addr;
        ctl.shift     = uop.shift;
        ctl.acc_op    = step ? uop.acc_op : ACC_HOLD;
    end

    assign emit = step && uop.emit;
    assign last = r_last && (vec || c_last);
    assign busy = busy_reg;
    assign r    = r_reg;
    assign c    = c_reg;
    assign l    = l_reg;

endmodule

`default_nettype wire

@@ hdl/bmo_dpath.sv @@
`default_nettype none

module bmo_dpath #(
    parameter int DIM       = 5,
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic                         wr_sel,
    input  logic [bmo_pkg::ROW_W-1:0]    wr_row,
    input  logic [bmo_pkg::ROW_W-1:0]    wr_col,
    input  logic [bmo_pkg::DATA_W-1:0]   wr_data,
    input  bmo_pkg::ctl_t                ctl,
    input  logic [$clog2(DIM)-1:0]       r,
    input  logic [$clog2(DIM)-1:0]       c,
    input  logic [$clog2(DIM)-1:0]       l,
    input  logic                         sub,
    output logic [bmo_pkg::DATA_W-1:0]   res_value,
    output logic                         res_sat
);
    import bmo_pkg::*;

    localparam int IDX_W = $clog2(DIM * DIM);
    localparam int ACC_W = 2 * DATA_W + $clog2(DIM);
    localparam int HI_W  = ACC_W - DATA_W + 1;
    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic [DATA_W-1:0]          mem_a [DIM*DIM];
    logic [DATA_W-1:0]          mem_b [DIM*DIM];

    logic [IDX_W-1:0]           wr_idx;
    logic [IDX_W-1:0]           a_idx, b_idx;
    logic signed [DATA_W-1:0]   a_rd_reg, b_rd_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    shifted;
    logic [HI_W-1:0]            hi;
    logic                       in_range;

    assign wr_idx = IDX_W'(wr_row) * IDX_W'(DIM) + IDX_W'(wr_col);

    // product terms: A(r,l) * B(l,c); elementwise: A(r,c), B(r,c)
    always_comb
    begin
        if (ctl.term_addr)
        begin
            a_idx = IDX_W'(r) * IDX_W'(DIM) + IDX_W'(l);
            b_idx = IDX_W'(l) * IDX_W'(DIM) + IDX_W'(c);
        end
        else
        begin
            a_idx = IDX_W'(r) * IDX_W'(DIM) + IDX_W'(c);
            b_idx = a_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_sel)
            mem_a[wr_idx] <= wr_data;
        if (wr_en && wr_sel)
            mem_b[wr_idx] <= wr_data;
        if (ctl.rd)
        begin
            a_rd_reg <= mem_a[a_idx];
            b_rd_reg <= mem_b[b_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
            prod_reg <= a_rd_reg * b_rd_reg;
        unique case (ctl.acc_op)
            ACC_HOLD:     acc_reg <= acc_reg;
            ACC_CLR:      acc_reg <= '0;
            ACC_ADD_PROD: acc_reg <= acc_reg + ACC_W'(prod_reg);
            ACC_LOAD_SUM: acc_reg <= sub ? ACC_W'(a_rd_reg) - ACC_W'(b_rd_reg)
                                         : ACC_W'(a_rd_reg) + ACC_W'(b_rd_reg);
            default:      acc_reg <= acc_reg;
        endcase
    end

    // product results: arithmetic shift floors; all results then clip to 32 bits
    assign shifted  = ctl.shift ? (acc_reg >>> FRAC_BITS) : acc_reg;
    assign hi       = shifted[ACC_W-1:DATA_W-1];
    assign in_range = (&hi) || !(|hi);
    assign res_sat  = !in_range;
    assign res_value = in_range ? shifted[DATA_W-1:0]
                                : (shifted[ACC_W-1] ? VAL_MIN : VAL_MAX);

endmodule

`default_nettype wire

@@ sim/tb_block_matrix_ops_5x5.sv @@
`default_nettype none

module tb_block_matrix_ops_5x5;

    import bmo_pkg::*;

    localparam int N              = DIM_DEF;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES   = 450;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 200;

    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] VAL_NEG = 32'hFFFF_FFFF;

    // 5 products of two 32-bit values need 67 bits
    localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
    localparam logic signed [66:0] SAT_LO = -67'sd2147483648;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              last;
    } result_elem_t;

    class matops_scoreboard;
        logic signed [DATA_W-1:0] a_store [N*N];
        logic signed [DATA_W-1:0] b_store [N*N];
        logic [OP_W-1:0]          mode;
        result_elem_t             expected_elems [$];
        int                       errors;

        function new();
            mode   = OP_MAT_MUL;
            errors = 0;
            foreach (a_store[i])
            begin
                a_store[i] = '0;
                b_store[i] = '0;
            end
        endfunction

        function void set_mode(logic [OP_W-1:0] m);
            mode = m;
        endfunction

        function int pending();
            return expected_elems.size();
        endfunction

        function void queue_result(int r, int c, logic signed [66:0] v, bit last);
            result_elem_t e;
            e.row  = ROW_W'(r);
            e.col  = ROW_W'(c);
            e.last = last;
            if (v > SAT_HI)
            begin
                e.value = SAT_HI[DATA_W-1:0];
                e.sat   = 1'b1;
            end
            else if (v < SAT_LO)
            begin
                e.value = SAT_LO[DATA_W-1:0];
                e.sat   = 1'b1;
            end
            else
            begin
                e.value = v[DATA_W-1:0];
                e.sat   = 1'b0;
            end
            expected_elems.push_back(e);
        endfunction

        // row r of A times column c of B, exact sum then arithmetic shift
        function logic signed [66:0] dot_row_col(int r, int c);
            logic signed [66:0] acc;
            logic signed [66:0] term;
            longint             p;
            acc = '0;
            for (int l = 0; l < N; l++)
            begin
                p    = longint'(a_store[r*N+l]) * longint'(b_store[l*N+c]);
                term = 67'(p);
                acc  = acc + term;
            end
            return acc >>> FRAC;
        endfunction

        function logic signed [66:0] add_sub(int idx, bit minus);
            longint x;
            longint y;
            x = longint'(a_store[idx]);
            y = longint'(b_store[idx]);
            return 67'(minus ? x - y : x + y);
        endfunction

        function void load_element(logic sel, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                   logic [DATA_W-1:0] value, logic eoc);
            if (row < N && col < N)
            begin
                if (sel)
                    b_store[row*N+col] = value;
                else
                    a_store[row*N+col] = value;
            end
            if (!eoc)
                return;
            case (mode)
                OP_MAT_MUL:
                    for (int r = 0; r < N; r++)
                        for (int c = 0; c < N; c++)
                            queue_result(r, c, dot_row_col(r, c), r == N-1 && c == N-1);
                OP_MAT_ADD, OP_MAT_SUB:
                    for (int r = 0; r < N; r++)
                        for (int c = 0; c < N; c++)
                            queue_result(r, c, add_sub(r*N+c, mode == OP_MAT_SUB),
                                         r == N-1 && c == N-1);
                OP_MAT_VEC:
                    for (int r = 0; r < N; r++)
                        queue_result(r, 0, dot_row_col(r, 0), r == N-1);
                OP_VEC_ADD, OP_VEC_SUB:
                    for (int r = 0; r < N; r++)
                        queue_result(r, 0, add_sub(r*N, mode == OP_VEC_SUB), r == N-1);
                default:
                    ; // unused modes produce nothing
            endcase
        endfunction

        function void check_element(result_elem_t got);
            result_elem_t want;
            if (expected_elems.size() == 0)
            begin
                $display("%0t: unexpected result transfer row %0d col %0d value %h",
                         $time, got.row, got.col, got.value);
                errors++;
                return;
            end
            want = expected_elems.pop_front();
            if (got.row !== want.row)
            begin
                $display("%0t: out_row expected %0d, actual %0d", $time, want.row, got.row);
                errors++;
            end
            if (got.col !== want.col)
            begin
                $display("%0t: out_col expected %0d, actual %0d", $time, want.col, got.col);
                errors++;
            end
            if (got.value !== want.value)
            begin
                $display("%0t: out_value (%0d,%0d) expected %h, actual %h",
                         $time, want.row, want.col, want.value, got.value);
                errors++;
            end
            if (got.sat !== want.sat)
            begin
                $display("%0t: saturated (%0d,%0d) expected %b, actual %b",
                         $time, want.row, want.col, want.sat, got.sat);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_out (%0d,%0d) expected %b, actual %b",
                         $time, want.row, want.col, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [OP_W-1:0]   cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic              operand_sel;
    logic [ROW_W-1:0]  elem_row;
    logic [ROW_W-1:0]  elem_col;
    logic [DATA_W-1:0] elem_value;
    logic              end_of_cell;
    logic              out_valid;
    logic              out_ready;
    logic [ROW_W-1:0]  out_row;
    logic [ROW_W-1:0]  out_col;
    logic [DATA_W-1:0] out_value;
    logic              saturated;
    logic              last_out;

    matops_scoreboard results_sb = new();
    int               burst_left = 0;
    int               sent_items = 0;
    int               stall_cycles = 0;

    block_matrix_ops_5x5 DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operand_sel (operand_sel),
        .elem_row    (elem_row),
        .elem_col    (elem_col),
        .elem_value  (elem_value),
        .end_of_cell (end_of_cell),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .saturated   (saturated),
        .last_out    (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    3: return VAL_NEG;
                    default: return VAL_ONE;
                endcase
            end
            2, 3: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    // mostly valid positions; vector modes favor column 0
    function automatic void pick_position(output logic [ROW_W-1:0] row,
                                          output logic [ROW_W-1:0] col);
        case ($urandom_range(0, 11))
            0:
            begin
                row = ROW_W'($urandom_range(N, 7));
                col = ROW_W'($urandom_range(0, 7));
            end
            1:
            begin
                row = ROW_W'($urandom_range(0, N-1));
                col = ROW_W'($urandom_range(N, 7));
            end
            default:
            begin
                row = ROW_W'($urandom_range(0, N-1));
                if (results_sb.mode >= OP_MAT_VEC && $urandom_range(0, 1) == 1)
                    col = '0;
                else
                    col = ROW_W'($urandom_range(0, N-1));
            end
        endcase
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
    endtask

    task automatic send_elem(logic sel, logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                             logic [DATA_W-1:0] value, logic eoc);
        pace_sender();
        @(negedge clk);
        in_valid    <= 1'b1;
        operand_sel <= sel;
        elem_row    <= row;
        elem_col    <= col;
        elem_value  <= value;
        end_of_cell <= eoc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        results_sb.load_element(sel, row, col, value, eoc);
        sent_items++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_op_mode(logic [OP_W-1:0] m);
        wait_for_results();
        // an end transfer in an unused mode gives no result to wait on
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        results_sb.set_mode(m);
    endtask

    initial
    begin
        int              rx_left;
        logic            rx_ready;
        rx_left   = 0;
        rx_ready  = 1'b1;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        rx_ready = 1'b1;
                        rx_left  = $urandom_range(20, 60);
                    end
                    4, 5, 6:
                    begin
                        rx_ready = 1'b0;
                        rx_left  = $urandom_range(1, 6);
                    end
                    default:
                    begin
                        rx_ready = 1'b1;
                        rx_left  = $urandom_range(1, 3);
                    end
                endcase
            end
            out_ready <= rx_ready;
            rx_left--;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_elem_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.row   = out_row;
            got.col   = out_col;
            got.value = out_value;
            got.sat   = saturated;
            got.last  = last_out;
            results_sb.check_element(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int               phase;
        int               cells;
        int               loads;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [OP_W-1:0]  m;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        operand_sel = 1'b0;
        elem_row    = '0;
        elem_col    = '0;
        elem_value  = '0;
        end_of_cell = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill both stores so no unwritten entry is ever read; reset mode is product
        for (int i = 0; i < 2*N*N; i++)
            send_elem(1'(i / (N*N)), ROW_W'((i % (N*N)) / N), ROW_W'(i % N), rand_value(),
                      i == 2*N*N-1);

        // product saturating both ways
        send_elem(1'b0, 0, 0, VAL_MAX, 1'b0);
        send_elem(1'b0, 1, 0, VAL_MIN, 1'b0);
        send_elem(1'b1, 0, 0, VAL_MAX, 1'b1);
        write_op_mode(OP_MAT_ADD);
        send_elem(1'b1, 1, 0, VAL_MIN, 1'b0);
        send_elem(1'b1, 0, 0, VAL_MAX, 1'b1);
        write_op_mode(OP_MAT_SUB);
        send_elem(1'b1, 1, 0, VAL_MAX, 1'b0);
        send_elem(1'b1, 0, 0, VAL_MIN, 1'b1);
        // out of range element on the end transfer: dropped, cell still runs
        write_op_mode(OP_MAT_VEC);
        send_elem(1'b1, 7, 7, VAL_MAX, 1'b1);
        write_op_mode(OP_VEC_ADD);
        send_elem(1'b0, 5, 0, VAL_MIN, 1'b0);
        send_elem(1'b0, 3, 6, VAL_NEG, 1'b1);
        // element carried by the end transfer is used
        write_op_mode(OP_VEC_SUB);
        send_elem(1'b0, 2, 0, '0, 1'b1);
        write_op_mode(OP_RSVD_6);
        send_elem(1'b0, 4, 4, VAL_ONE, 1'b1);
        write_op_mode(OP_RSVD_7);
        send_elem(1'b1, 4, 4, VAL_MIN, 1'b1);
        write_op_mode(OP_MAT_MUL);
        send_elem(1'b0, 2, 2, VAL_NEG, 1'b0);
        send_elem(1'b1, 2, 2, VAL_ONE, 1'b1);

        phase = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            m = (phase < 8) ? OP_W'(phase) : OP_W'($urandom_range(0, 7));
            write_op_mode(m);
            cells = $urandom_range(2, 5);
            repeat (cells)
            begin
                loads = $urandom_range(0, 8);
                repeat (loads)
                begin
                    pick_position(row, col);
                    send_elem(1'($urandom_range(0, 1)), row, col, rand_value(), 1'b0);
                end
                pick_position(row, col);
                send_elem(1'($urandom_range(0, 1)), row, col, rand_value(), 1'b1);
                if ($urandom_range(0, 7) == 0)
                    wait_for_results();
            end
            phase++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (results_sb.errors == 0 && results_sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/bmo_pkg.sv
hdl/bmo_seq.sv
hdl/bmo_dpath.sv
hdl/block_matrix_ops_5x5.sv
sim/tb_block_matrix_ops_5x5.sv
